@@ design/gap_buffer_text_editor_macros.svh @@
// Assertion macros for the gap buffer text editor.
// Used by the top level; expects signals clk and rst in scope.
`ifndef GAP_BUFFER_TEXT_EDITOR_MACROS_SVH
`define GAP_BUFFER_TEXT_EDITOR_MACROS_SVH

`ifndef NO_ASSERTIONS
// checked only outside reset
`define GBTE_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked at every edge, reset included
`define GBTE_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GBTE_ASSERT(name, prop, msg)
`define GBTE_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

@@ design/gbte_pkg.sv @@
// Shared types and constants for the gap buffer text editor.
// No dependencies.
package gbte_pkg;

  localparam int CAPACITY_DEF = 4096;
  localparam int FIELD_W      = 13;
  localparam int CHAR_W       = 8;
  localparam int ACTION_W     = 3;

  localparam logic [CHAR_W-1:0] NEWLINE = 8'h0A;

  localparam logic [ACTION_W-1:0] ACT_INSERT = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_LEFT   = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_RIGHT  = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_BACK   = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_READ   = 3'd4;

  typedef struct packed {
    logic [CHAR_W-1:0]  char_out;
    logic               char_valid;
    logic [FIELD_W-1:0] cursor_pos;
    logic [FIELD_W-1:0] column;
    logic [FIELD_W-1:0] line;
    logic [FIELD_W-1:0] text_length;
    logic               full_res;
  } gbte_result_t;

endpackage

@@ design/gbte_store.sv @@
// Text store: single-port byte memory with registered read data.
// Depends on gbte_pkg.
module gbte_store import gbte_pkg::*; #(
  parameter int DEPTH = CAPACITY_DEF,
  parameter int AW    = $clog2(CAPACITY_DEF)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     addr,
  input  logic [CHAR_W-1:0] wdata,
  output logic [CHAR_W-1:0] rdata
);

  logic [CHAR_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ design/gbte_seq.sv @@
// Edit sequencer: gap pointers, column/line tracking and newline back-scan,
// all driven through the one port of the text store. Depends on gbte_pkg.
module gbte_seq import gbte_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int AW       = $clog2(CAPACITY_DEF)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [ACTION_W-1:0] action,
  input  logic [CHAR_W-1:0]   char_in,
  input  logic [FIELD_W-1:0]  read_index,
  input  logic                out_free,
  output logic                done,
  output gbte_result_t        result,
  output logic                mem_we,
  output logic [AW-1:0]       mem_addr,
  output logic [CHAR_W-1:0]   mem_wdata,
  input  logic [CHAR_W-1:0]   mem_rdata
);

  localparam int PW = $clog2(CAPACITY + 1);
  localparam int CW = (PW > FIELD_W) ? PW : FIELD_W;

  typedef enum logic [2:0] {
    S_IDLE, S_LEFT, S_RIGHT, S_BACK, S_READ, S_SCAN_RD, S_SCAN_CK, S_DONE
  } state_t;

  state_t state;
  logic [PW-1:0] gb, gl, col, lin, n;
  logic [CHAR_W-1:0] char_o;
  logic cvalid, full;

  logic [PW-1:0] gb_plus_gl, gbgl_m1, gb_m1, scan_addr, len;
  logic [CW-1:0] idx_w, gb_w, len_w, gl_w, idx_far;
  logic [CW-1:0] col_w, lin_w;
  logic right_ok, read_lo, read_hi, c_nl;

  always_comb begin
    gb_plus_gl = gb + gl;
    gbgl_m1    = gb_plus_gl - PW'(1);
    gb_m1      = gb - PW'(1);
    scan_addr  = gb - n - PW'(1);
    len        = PW'(CAPACITY) - gl;
    right_ok   = gb_plus_gl < PW'(CAPACITY);
    idx_w      = CW'(read_index);
    gb_w       = CW'(gb);
    gl_w       = CW'(gl);
    len_w      = CW'(len);
    col_w      = CW'(col);
    lin_w      = CW'(lin);
    idx_far    = idx_w + gl_w;
    read_lo    = idx_w < gb_w;
    read_hi    = idx_w < len_w;
    c_nl       = mem_rdata == NEWLINE;
  end

  assign in_ready = state == S_IDLE;
  assign done     = (state == S_DONE) && out_free;

  always_comb begin
    result.char_out    = char_o;
    result.char_valid  = cvalid;
    result.cursor_pos  = gb_w[FIELD_W-1:0];
    result.column      = col_w[FIELD_W-1:0];
    result.line        = lin_w[FIELD_W-1:0];
    result.text_length = len_w[FIELD_W-1:0];
    result.full_res    = full;
  end

  // store port
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = '0;
    mem_wdata = mem_rdata;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          unique case (action)
            ACT_INSERT: begin
              mem_we    = gl != '0;
              mem_addr  = gb[AW-1:0];
              mem_wdata = char_in;
            end
            ACT_LEFT, ACT_BACK: mem_addr = gb_m1[AW-1:0];
            ACT_RIGHT:          mem_addr = gb_plus_gl[AW-1:0];
            ACT_READ:           mem_addr = read_lo ? idx_w[AW-1:0] : idx_far[AW-1:0];
            default:            mem_addr = '0;
          endcase
        end
      end
      S_LEFT: begin
        mem_we   = 1'b1;
        mem_addr = gbgl_m1[AW-1:0];
      end
      S_RIGHT: begin
        mem_we   = 1'b1;
        mem_addr = gb[AW-1:0];
      end
      S_SCAN_RD: mem_addr = scan_addr[AW-1:0];
      default:   mem_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      gb    <= '0;
      gl    <= PW'(CAPACITY);
      col   <= '0;
      lin   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            char_o <= '0;
            cvalid <= 1'b0;
            full   <= 1'b0;
            n      <= '0;
            state  <= S_DONE;
            unique case (action)
              ACT_INSERT: begin
                if (gl == '0) begin
                  full <= 1'b1;
                end else begin
                  gb <= gb + PW'(1);
                  gl <= gl - PW'(1);
                  if (char_in == NEWLINE) begin
                    col <= '0;
                    lin <= lin + PW'(1);
                  end else begin
                    col <= col + PW'(1);
                  end
                end
              end
              ACT_LEFT: begin
                if (gb != '0) state <= S_LEFT;
              end
              ACT_RIGHT: begin
                if (right_ok) state <= S_RIGHT;
              end
              ACT_BACK: begin
                if (gb != '0) begin
                  gb    <= gb_m1;
                  gl    <= gl + PW'(1);
                  state <= S_BACK;
                end
              end
              ACT_READ: begin
                if (read_lo || read_hi) state <= S_READ;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_LEFT, S_BACK: begin
          // character left of the cursor as it stood at accept is in mem_rdata
          if (state == S_LEFT) gb <= gb_m1;
          if (c_nl) begin
            if (lin != '0) lin <= lin - PW'(1);
            state <= S_SCAN_RD;
          end else begin
            if (col != '0) col <= col - PW'(1);
            state <= S_DONE;
          end
        end
        S_RIGHT: begin
          gb <= gb + PW'(1);
          if (c_nl) begin
            col <= '0;
            lin <= lin + PW'(1);
          end else begin
            col <= col + PW'(1);
          end
          state <= S_DONE;
        end
        S_READ: begin
          char_o <= mem_rdata;
          cvalid <= 1'b1;
          state  <= S_DONE;
        end
        S_SCAN_RD: begin
          if (n < gb) begin
            state <= S_SCAN_CK;
          end else begin
            col   <= n;
            state <= S_DONE;
          end
        end
        S_SCAN_CK: begin
          if (c_nl) begin
            col   <= n;
            state <= S_DONE;
          end else begin
            n     <= n + PW'(1);
            state <= S_SCAN_RD;
          end
        end
        S_DONE: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ design/gap_buffer_text_editor.sv @@
// Channel  | handshake             | payload
// ---------+-----------------------+------------------------------------------
// in       | in_valid / in_ready   | action, char_in, read_index
// out      | out_valid / out_ready | char_out, char_valid, cursor_pos, column,
//          |                       | line, text_length, full_res
//
// One item at a time; in_ready drops from accept until its result is handed to
// the output register. The single store port sets the sequencer steps: insert,
// unused codes, reads outside the text and moves that change nothing go straight
// from idle to the done state; a read, right, left or backspace first reads the
// store; a left or backspace over a newline then back-scans the text, one char
// at a time, for the previous newline or text start. The output register lets
// the next item enter while a result waits. Reset is synchronous; the store itself is never cleared.
// Depends on gbte_pkg, gbte_seq, gbte_store and the assertion macro header.
`include "gap_buffer_text_editor_macros.svh"
module gap_buffer_text_editor import gbte_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [ACTION_W-1:0] action,
  input  logic [CHAR_W-1:0]   char_in,
  input  logic [FIELD_W-1:0]  read_index,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [CHAR_W-1:0]   char_out,
  output logic                char_valid,
  output logic [FIELD_W-1:0]  cursor_pos,
  output logic [FIELD_W-1:0]  column,
  output logic [FIELD_W-1:0]  line,
  output logic [FIELD_W-1:0]  text_length,
  output logic                full_res
);

  localparam int AW = $clog2(CAPACITY);

  logic              out_free, res_load;
  gbte_result_t      res_next, res;
  logic              mem_we;
  logic [AW-1:0]     mem_addr;
  logic [CHAR_W-1:0] mem_wdata, mem_rdata;

  assign out_free = !out_valid || out_ready;

  gbte_seq #(.CAPACITY(CAPACITY), .AW(AW)) u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .action    (action),
    .char_in   (char_in),
    .read_index(read_index),
    .out_free  (out_free),
    .done      (res_load),
    .result    (res_next),
    .mem_we    (mem_we),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata)
  );

  gbte_store #(.DEPTH(CAPACITY), .AW(AW)) u_store (
    .clk  (clk),
    .we   (mem_we),
    .addr (mem_addr),
    .wdata(mem_wdata),
    .rdata(mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (res_load) res <= res_next;
  end

  assign char_out    = res.char_out;
  assign char_valid  = res.char_valid;
  assign cursor_pos  = res.cursor_pos;
  assign column      = res.column;
  assign line        = res.line;
  assign text_length = res.text_length;
  assign full_res    = res.full_res;

  `GBTE_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "output valid after reset")
  `GBTE_ASSERT(a_no_overwrite, res_load |-> (!out_valid || out_ready), "result overwritten")
  `GBTE_ASSERT(a_busy_after_accept, (in_valid && in_ready) |=> !in_ready, "accepted while busy")
  `GBTE_ASSERT(a_full_len, (out_valid && full_res) |-> (text_length == FIELD_W'(CAPACITY)), "full")

endmodule
